// ===== rtl/afbs_pkg.sv =====
`timescale 1ns / 1ps

package afbs_pkg;

  // field widths of the transactions
  localparam int unsigned LEN_W     = 31;
  localparam int unsigned SZ_W      = 16;
  localparam int unsigned KIND_W    = 2;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned PROD_W    = 2 * SZ_W;

  // command queue between front and back
  localparam int unsigned CMD_FIFO_DEPTH = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_UNIT_BYTES = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_UNITS  = 1'b1;

  // register reset values
  localparam logic [SZ_W-1:0] UNIT_BYTES_RST = 16'd1024;
  localparam logic [SZ_W-1:0] MAX_UNITS_RST  = 16'd64;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_NEXT  = 1'b1
  } cmd_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_SUMMARY = 2'd0,
    KIND_UNIT    = 2'd1,
    KIND_IDLE    = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [LEN_W-1:0]  block_index;
    logic [SZ_W-1:0]   unit_index;
    logic [SZ_W-1:0]   unit_length;
    logic [LEN_W-1:0]  byte_offset;
    logic [SZ_W-1:0]   block_unit_count;
    logic [LEN_W-1:0]  block_bytes;
    logic [LEN_W-1:0]  total_units;
    logic [LEN_W-1:0]  total_blocks;
    logic              last_in_block;
    logic              last_in_adu;
  } res_t;

endpackage

// ===== rtl/afbs_if.sv =====
`timescale 1ns / 1ps

// request channel: start or next
interface afbs_in_if;
  import afbs_pkg::*;
  logic             valid;
  logic             ready;
  logic             action;
  logic [LEN_W-1:0] adu_length;

  modport source (output valid, output action, output adu_length, input ready);
  modport sink (input valid, input action, input adu_length, output ready);
endinterface

// result channel: summary, descriptor or idle
interface afbs_out_if;
  import afbs_pkg::*;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [LEN_W-1:0]  block_index;
  logic [SZ_W-1:0]   unit_index;
  logic [SZ_W-1:0]   unit_length;
  logic [LEN_W-1:0]  byte_offset;
  logic [SZ_W-1:0]   block_unit_count;
  logic [LEN_W-1:0]  block_bytes;
  logic [LEN_W-1:0]  total_units;
  logic [LEN_W-1:0]  total_blocks;
  logic              last_in_block;
  logic              last_in_adu;

  modport source (output valid, output kind, output block_index, output unit_index,
                  output unit_length, output byte_offset, output block_unit_count,
                  output block_bytes, output total_units, output total_blocks,
                  output last_in_block, output last_in_adu, input ready);
  modport sink (input valid, input kind, input block_index, input unit_index,
                input unit_length, input byte_offset, input block_unit_count,
                input block_bytes, input total_units, input total_blocks,
                input last_in_block, input last_in_adu, output ready);
endinterface

// ===== rtl/afbs_front.sv =====
`timescale 1ns / 1ps

module afbs_front #(
  parameter int unsigned LENGTH_BITS = 31
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  afbs_in_if.sink              in_if,
  output logic                 cmd_valid_o,
  input  logic                 cmd_ready_i,
  output afbs_pkg::cmd_e       cmd_o,
  output logic [LENGTH_BITS-1:0] cmd_len_o
);
  import afbs_pkg::*;

  logic                   valid_q;
  cmd_e                   cmd_q, cmd_d;
  logic [LENGTH_BITS-1:0] len_q, len_d;
  logic                   take;

  // stage is free when empty or draining this cycle
  assign in_if.ready = !valid_q || cmd_ready_i;
  assign take        = in_if.valid && in_if.ready;

  // classify the request, length only kept for a start
  always_comb begin
    cmd_d = in_if.action ? CMD_NEXT : CMD_START;
    len_d = (cmd_d == CMD_START) ? in_if.adu_length[LENGTH_BITS-1:0] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (take) begin
      valid_q <= 1'b1;
    end else if (cmd_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      cmd_q <= cmd_d;
      len_q <= len_d;
    end
  end

  assign cmd_valid_o = valid_q;
  assign cmd_o       = cmd_q;
  assign cmd_len_o   = len_q;

endmodule

// ===== rtl/afbs_cmd_fifo.sv =====
`timescale 1ns / 1ps

module afbs_cmd_fifo #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_valid_i,
  output logic             wr_ready_o,
  input  logic [WIDTH-1:0] wr_data_i,
  output logic             rd_valid_o,
  input  logic             rd_ready_i,
  output logic [WIDTH-1:0] rd_data_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;
  logic             push, pop;

  assign wr_ready_o = count_q != FullCnt;
  assign rd_valid_o = count_q != '0;
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;
  assign rd_data_o  = mem_q[rd_ptr_q];

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullCnt)
    else $error("command queue overfilled");
`endif

endmodule

// ===== rtl/afbs_ceil_div.sv =====
`timescale 1ns / 1ps

module afbs_ceil_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [afbs_pkg::LEN_W-1:0] dividend_i,
  input  logic [afbs_pkg::SZ_W-1:0]  divisor_i,
  output logic                       done_o,
  output logic [afbs_pkg::LEN_W-1:0] quotient_o
);
  import afbs_pkg::*;

  localparam int unsigned Steps = LEN_W;
  localparam int unsigned CntW  = $clog2(Steps + 1);

  logic              busy_q, done_q;
  logic [CntW-1:0]   cnt_q;
  logic [LEN_W-1:0]  dvd_q, dvd_d;
  logic [SZ_W-1:0]   rem_q, rem_d;
  logic [SZ_W-1:0]   dvs_q;
  logic [SZ_W:0]     shifted;
  logic              ge;

  // one restoring step per cycle, quotient bits shift in from the right
  always_comb begin
    shifted = {rem_q, dvd_q[LEN_W-1]};
    ge      = shifted >= {1'b0, dvs_q};
    rem_d   = ge ? SZ_W'(shifted - {1'b0, dvs_q}) : shifted[SZ_W-1:0];
    dvd_d   = {dvd_q[LEN_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CntW'(Steps);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      dvd_q <= dvd_d;
      rem_q <= rem_d;
    end
  end

  // round up when a remainder is left
  assign done_o     = done_q;
  assign quotient_o = dvd_q + LEN_W'(rem_q != '0);

`ifndef SYNTHESIS
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider restarted while busy");
`endif

endmodule

// ===== rtl/afbs_back.sv =====
`timescale 1ns / 1ps

module afbs_back #(
  parameter int unsigned LENGTH_BITS = 31
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [afbs_pkg::SZ_W-1:0]   unit_bytes_i,
  input  logic [afbs_pkg::SZ_W-1:0]   max_units_i,
  input  logic                        cmd_valid_i,
  output logic                        cmd_ready_o,
  input  afbs_pkg::cmd_e              cmd_i,
  input  logic [LENGTH_BITS-1:0]      cmd_len_i,
  output logic                        res_valid_o,
  input  logic                        res_ready_i,
  output afbs_pkg::res_t              res_o
);
  import afbs_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIVU = 4'b0010,
    ST_DIVB = 4'b0100,
    ST_SUM  = 4'b1000
  } state_e;

  state_e            state_q, state_d;
  logic              pending_q, pending_d;
  logic [LEN_W-1:0]  rem_bytes_q, rem_bytes_d;
  logic [LEN_W-1:0]  rem_units_q, rem_units_d;
  logic [LEN_W-1:0]  next_off_q, next_off_d;
  logic [LEN_W-1:0]  cur_block_q, cur_block_d;
  logic [SZ_W-1:0]   uib_q, uib_d;
  logic [SZ_W-1:0]   utb_q, utb_d;
  logic [LEN_W-1:0]  btb_q, btb_d;
  logic [LEN_W-1:0]  unit_total_q, unit_total_d;
  logic [LEN_W-1:0]  block_total_q, block_total_d;
  logic [SZ_W-1:0]   lat_p_q, lat_p_d;
  logic [SZ_W-1:0]   lat_k_q, lat_k_d;
  logic [PROD_W-1:0] kp_q, kp_d;
  res_t              res_q, res_d;
  logic              res_valid_q, res_load;

  logic              slot_free;
  logic [SZ_W-1:0]   p_eff, k_eff;
  logic              div_start, div_done;
  logic [LEN_W-1:0]  div_dvd, div_quo;
  logic [SZ_W-1:0]   div_dvs;

  // block opening and unit step
  logic              full_block;
  logic [SZ_W-1:0]   ob_units;
  logic [LEN_W-1:0]  ob_bytes;
  logic              uib_zero;
  logic [SZ_W-1:0]   utb;
  logic [LEN_W-1:0]  btb;
  logic [SZ_W-1:0]   ulen;
  logic              lib, lia;

  assign slot_free   = !res_valid_q || res_ready_i;
  assign cmd_ready_o = (state_q == ST_IDLE) && slot_free;
  assign p_eff       = (unit_bytes_i == '0) ? SZ_W'(1) : unit_bytes_i;
  assign k_eff       = (max_units_i == '0) ? SZ_W'(1) : max_units_i;

  afbs_ceil_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // a block is full-size unless the remaining units fit in it;
  // a partial block carries all remaining bytes
  always_comb begin
    full_block = rem_units_q > LEN_W'(lat_k_q);
    ob_units   = full_block ? lat_k_q : rem_units_q[SZ_W-1:0];
    ob_bytes   = full_block ? kp_q[LEN_W-1:0] : rem_bytes_q;
    uib_zero   = uib_q == '0;
    utb        = uib_zero ? ob_units : utb_q;
    btb        = uib_zero ? ob_bytes : btb_q;
    ulen       = (rem_bytes_q < LEN_W'(lat_p_q)) ? rem_bytes_q[SZ_W-1:0] : lat_p_q;
    lib        = ({1'b0, uib_q} + (SZ_W+1)'(1)) >= {1'b0, utb};
    lia        = rem_units_q <= LEN_W'(1);
  end

  // sequencing of start and next commands
  always_comb begin
    state_d       = state_q;
    pending_d     = pending_q;
    rem_bytes_d   = rem_bytes_q;
    rem_units_d   = rem_units_q;
    next_off_d    = next_off_q;
    cur_block_d   = cur_block_q;
    uib_d         = uib_q;
    utb_d         = utb_q;
    btb_d         = btb_q;
    unit_total_d  = unit_total_q;
    block_total_d = block_total_q;
    lat_p_d       = lat_p_q;
    lat_k_d       = lat_k_q;
    kp_d          = kp_q;
    div_start     = 1'b0;
    div_dvd       = LEN_W'(cmd_len_i);
    div_dvs       = p_eff;
    res_load      = 1'b0;
    res_d         = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i && cmd_ready_o) begin
          if (cmd_i == CMD_START) begin
            lat_p_d     = p_eff;
            lat_k_d     = k_eff;
            kp_d        = {{SZ_W{1'b0}}, p_eff} * {{SZ_W{1'b0}}, k_eff};
            rem_bytes_d = LEN_W'(cmd_len_i);
            div_start   = 1'b1;
            state_d     = ST_DIVU;
          end else if (!pending_q) begin
            res_load   = 1'b1;
            res_d.kind = KIND_IDLE;
          end else begin
            res_load               = 1'b1;
            res_d.kind             = KIND_UNIT;
            res_d.block_index      = cur_block_q;
            res_d.unit_index       = uib_q;
            res_d.unit_length      = ulen;
            res_d.byte_offset      = next_off_q;
            res_d.block_unit_count = utb;
            res_d.block_bytes      = btb;
            res_d.total_units      = unit_total_q;
            res_d.total_blocks     = block_total_q;
            res_d.last_in_block    = lib;
            res_d.last_in_adu      = lia;
            utb_d       = utb;
            btb_d       = btb;
            rem_bytes_d = rem_bytes_q - LEN_W'(ulen);
            rem_units_d = lia ? '0 : rem_units_q - 1'b1;
            next_off_d  = next_off_q + LEN_W'(ulen);
            if (lib || lia) begin
              uib_d       = '0;
              cur_block_d = cur_block_q + 1'b1;
            end else begin
              uib_d = uib_q + 1'b1;
            end
            if (lia) begin
              pending_d = 1'b0;
            end
          end
        end
      end
      ST_DIVU: begin
        if (div_done) begin
          rem_units_d  = div_quo;
          unit_total_d = div_quo;
          pending_d    = div_quo != '0;
          div_start    = 1'b1;
          div_dvd      = div_quo;
          div_dvs      = lat_k_q;
          state_d      = ST_DIVB;
        end
      end
      ST_DIVB: begin
        if (div_done) begin
          block_total_d = div_quo;
          next_off_d    = '0;
          cur_block_d   = '0;
          uib_d         = '0;
          state_d       = ST_SUM;
        end
      end
      ST_SUM: begin
        if (slot_free) begin
          utb_d                  = ob_units;
          btb_d                  = ob_bytes;
          res_load               = 1'b1;
          res_d.kind             = KIND_SUMMARY;
          res_d.block_unit_count = ob_units;
          res_d.block_bytes      = ob_bytes;
          res_d.total_units      = unit_total_q;
          res_d.total_blocks     = block_total_q;
          state_d                = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      pending_q     <= 1'b0;
      rem_bytes_q   <= '0;
      rem_units_q   <= '0;
      next_off_q    <= '0;
      cur_block_q   <= '0;
      uib_q         <= '0;
      utb_q         <= '0;
      btb_q         <= '0;
      unit_total_q  <= '0;
      block_total_q <= '0;
      lat_p_q       <= UNIT_BYTES_RST;
      lat_k_q       <= MAX_UNITS_RST;
      kp_q          <= PROD_W'(UNIT_BYTES_RST) * PROD_W'(MAX_UNITS_RST);
      res_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      pending_q     <= pending_d;
      rem_bytes_q   <= rem_bytes_d;
      rem_units_q   <= rem_units_d;
      next_off_q    <= next_off_d;
      cur_block_q   <= cur_block_d;
      uib_q         <= uib_d;
      utb_q         <= utb_d;
      btb_q         <= btb_d;
      unit_total_q  <= unit_total_d;
      block_total_q <= block_total_d;
      lat_p_q       <= lat_p_d;
      lat_k_q       <= lat_k_d;
      kp_q          <= kp_d;
      if (res_load) begin
        res_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

`ifndef SYNTHESIS
  a_pending_units: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pending_q && state_q == ST_IDLE) |-> rem_units_q != '0)
    else $error("pending with no units left");
  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIVU || state_q == ST_DIVB))
    else $error("division finished outside a start sequence");
  a_unit_in_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pending_q && state_q == ST_IDLE && uib_q != '0) |-> uib_q < utb_q)
    else $error("unit index ran past its block");
`endif

endmodule

// ===== rtl/adu_fec_block_segmenter_core.sv =====
`timescale 1ns / 1ps

// ADU segmenter: cuts an ADU into data units and groups them into FEC blocks.
// adu_in carries requests: action 0 starts an ADU of adu_length bytes, action 1
// asks for the next unit descriptor. desc_out carries one result per request:
// a start summary, a unit descriptor, or an idle result when nothing is pending.
// The config port writes the unit byte limit (index 0) and max_units_per_block
// (index 1); new values are latched by the next start.
// A request passes an input stage and a two-entry command queue before the
// execution unit; descriptors stream at one per cycle while the receiver is ready
// and no start is in progress.
// A start runs two serial ceiling divisions of 31 steps each (one quotient bit
// per cycle) before its summary leaves, and requests queued behind it wait.
// Reset clears all progress, the registers return to 1024 and 64, no ADU is
// pending. When the receiver stalls, the result register holds its transaction,
// the queue fills and adu_in.ready drops.
module adu_fec_block_segmenter_core #(
  parameter int unsigned LENGTH_BITS = 31
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [afbs_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [afbs_pkg::SZ_W-1:0]      cfg_wdata_i,
  afbs_in_if.sink                        adu_in,
  afbs_out_if.source                     desc_out
);
  import afbs_pkg::*;

  localparam int unsigned CmdW = LENGTH_BITS + 1;

  logic [SZ_W-1:0]        unit_bytes_q;
  logic [SZ_W-1:0]        max_units_q;

  logic                   fr_valid, fr_ready;
  cmd_e                   fr_cmd;
  logic [LENGTH_BITS-1:0] fr_len;
  logic                   q_valid, q_ready;
  logic [CmdW-1:0]        q_data;
  logic                   res_valid;
  res_t                   res;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unit_bytes_q <= UNIT_BYTES_RST;
      max_units_q  <= MAX_UNITS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_UNIT_BYTES: unit_bytes_q <= cfg_wdata_i;
        CFG_MAX_UNITS:  max_units_q  <= cfg_wdata_i;
        default:        unit_bytes_q <= unit_bytes_q;
      endcase
    end
  end

  afbs_front #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_if       (adu_in),
    .cmd_valid_o (fr_valid),
    .cmd_ready_i (fr_ready),
    .cmd_o       (fr_cmd),
    .cmd_len_o   (fr_len)
  );

  afbs_cmd_fifo #(
    .WIDTH (CmdW),
    .DEPTH (CMD_FIFO_DEPTH)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fr_valid),
    .wr_ready_o (fr_ready),
    .wr_data_i  ({fr_cmd, fr_len}),
    .rd_valid_o (q_valid),
    .rd_ready_i (q_ready),
    .rd_data_o  (q_data)
  );

  afbs_back #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .unit_bytes_i   (unit_bytes_q),
    .max_units_i    (max_units_q),
    .cmd_valid_i    (q_valid),
    .cmd_ready_o    (q_ready),
    .cmd_i          (cmd_e'(q_data[LENGTH_BITS])),
    .cmd_len_i      (q_data[LENGTH_BITS-1:0]),
    .res_valid_o    (res_valid),
    .res_ready_i    (desc_out.ready),
    .res_o          (res)
  );

  // result transaction onto the output channel
  assign desc_out.valid            = res_valid;
  assign desc_out.kind             = res.kind;
  assign desc_out.block_index      = res.block_index;
  assign desc_out.unit_index       = res.unit_index;
  assign desc_out.unit_length      = res.unit_length;
  assign desc_out.byte_offset      = res.byte_offset;
  assign desc_out.block_unit_count = res.block_unit_count;
  assign desc_out.block_bytes      = res.block_bytes;
  assign desc_out.total_units      = res.total_units;
  assign desc_out.total_blocks     = res.total_blocks;
  assign desc_out.last_in_block    = res.last_in_block;
  assign desc_out.last_in_adu      = res.last_in_adu;

endmodule
